[hdl/assert_macros.svh]
// Assertion helpers used by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pli_pkg.sv]
package pli_pkg;

    // Fixed field widths of the interface.
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 5;

    // Shared add/subtract unit: 32-bit operands plus sign and carry room.
    localparam int ALU_W     = 34;

    // Product of a 32-bit slope magnitude and a 33-bit offset magnitude.
    localparam int MUL_STEPS = 33;
    localparam int PROD_W    = 66;

    // Final sum of the base ordinate and the scaled product, with headroom.
    localparam int FIN_W     = 67;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_FEW  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_PRIME,
        S_SHIFT,
        S_RD_LO,
        S_RD_HI,
        S_DIFF_DY,
        S_DIFF_DX,
        S_DIFF_DQ,
        S_DIV,
        S_SLOPE,
        S_MUL,
        S_FINAL
    } t_state;

endpackage

[hdl/piecewise_linear_interpolator.sv]
// An evaluate searches for the first breakpoint above the query, then reads the segment,
// divides for the slope and multiplies; an add searches and then shifts the table up;
// a duplicate or full add or an evaluate on fewer than two points ends after the search.
// Throughput: one item at a time; busy is high until the result strobe, and the next start
// is taken in the strobe cycle. The receiver cannot stall the result.
// Reset (synchronous, active low) empties the table; stored breakpoints are not cleared.
`include "assert_macros.svh"

module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    output logic               o_valid,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_slope,
    output logic [1:0]         o_status,
    output logic               o_saturated,
    output logic [4:0]         o_point_count
);

    // ------------------------------------------------------------------------------------
    // Sizing. The table index needs IW bits; the count and the search position can reach
    // MAX_POINTS itself, so they get CW bits. The slope dividend is the 33-bit magnitude
    // of dy shifted up by FRAC_BITS, and the divider retires one quotient bit per cycle.
    // ------------------------------------------------------------------------------------
    localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int DW  = 33 + FRAC_BITS;
    localparam int SCW = $clog2(DW);
    localparam int DWD = pli_pkg::DATA_W;
    localparam int AW  = pli_pkg::ALU_W;
    localparam int FW  = pli_pkg::FIN_W;
    localparam int PW  = pli_pkg::PROD_W;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
    localparam logic [FW-1:0] FIN_MAX = {{(FW - 31){1'b0}}, {31{1'b1}}};
    localparam logic [FW-1:0] FIN_MIN = {{(FW - 31){1'b1}}, {31{1'b0}}};

    // ------------------------------------------------------------------------------------
    // Breakpoint table. Two single-port-write, single-port-read memories with registered
    // read data. Entries are kept in strictly ascending order of x; only entries below the
    // count are ever used.
    // ------------------------------------------------------------------------------------
    logic [DWD-1:0] r_mem_x [MAX_POINTS];
    logic [DWD-1:0] r_mem_y [MAX_POINTS];
    logic [DWD-1:0] r_rd_x;
    logic [DWD-1:0] r_rd_y;

    // Sequencer and control state.
    pli_pkg::t_state r_state;
    pli_pkg::t_state n_state;
    logic            r_valid;
    logic [CW-1:0]   r_count;

    // Item and working registers.
    logic            r_cmd;
    logic [DWD-1:0]  r_x;
    logic [DWD-1:0]  r_y;
    logic [CW-1:0]   r_pos;
    logic            r_dup;
    logic [CW-1:0]   r_k;
    logic [DWD-1:0]  r_xlo;
    logic [DWD-1:0]  r_ylo;
    logic [DWD-1:0]  r_xhi;
    logic            r_dy_neg;
    logic [DWD-1:0]  r_dx;
    logic            r_dq_neg;
    logic [32:0]     r_dq_mag;
    logic [DW-1:0]   r_quo;
    logic [DWD-1:0]  r_rem;
    logic [SCW-1:0]  r_step;
    logic [PW-1:0]   r_acc;
    logic [DWD-1:0]  r_mcand;
    logic [DWD-1:0]  r_slope;
    logic            r_slope_neg;
    logic            r_sat;

    // Result registers.
    logic [DWD-1:0]    r_out_value;
    logic [DWD-1:0]    r_out_slope;
    pli_pkg::t_status  r_out_status;
    logic              r_out_sat;

    // Control outputs of the sequencer.
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [DWD-1:0]  wr_x;
    logic [DWD-1:0]  wr_y;
    logic [AW-1:0]   alu_a;
    logic [AW-1:0]   alu_b;
    logic            alu_sub;
    logic            finish;

    // Shared arithmetic unit and the values derived from it.
    logic [AW-1:0]   alu_res;
    logic [AW-1:0]   alu_neg;
    logic [32:0]     alu_mag;
    logic            alu_is_neg;

    logic            accept;
    logic            search_stop;
    logic            is_full;
    logic            too_few;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   k_m2;
    logic [CW-1:0]   pos_p1;
    logic [CW-1:0]   seg_hi;
    logic [CW-1:0]   seg_lo;
    logic [32:0]     div_shift;
    logic            div_take;
    logic            q_big;
    logic [DWD-1:0]  q_cap;
    logic            slope_clip;
    logic [DWD-1:0]  slope_val;
    logic [DWD-1:0]  mcand_val;
    logic [FW-1:0]   fin_m;
    logic [FW-1:0]   fin_ylo;
    logic [FW-1:0]   fin_term;
    logic [FW-1:0]   fin_sum;
    logic            fin_hi;
    logic            fin_lo;
    logic [CW+4:0]   cnt_wide;

    assign accept = start && !busy;
    assign busy   = (r_state != pli_pkg::S_IDLE);

    // ------------------------------------------------------------------------------------
    // The shared adder/subtractor of the block. It compares during the search, forms dy, dx
    // and the query offset, performs each restoring division step and each shift-and-add
    // multiplication step.
    // ------------------------------------------------------------------------------------
    assign alu_res    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg    = -alu_res;
    assign alu_is_neg = alu_res[AW-1];
    assign alu_mag    = alu_is_neg ? alu_neg[32:0] : alu_res[32:0];

    // Search stops at the end of the table or at the first x above the query.
    assign search_stop = (r_pos >= r_count) || alu_is_neg;
    assign is_full     = (r_count >= CNT_MAX);
    assign too_few     = (r_count < CW'(2));
    assign cnt_m1      = r_count - CW'(1);
    assign k_m2        = r_k - CW'(2);
    assign pos_p1      = r_pos + CW'(1);

    // Segment choice: clamp the search position into the range of interior segments, so
    // queries outside the table extrapolate along the first or last segment.
    always_comb begin
        priority if (r_pos == '0) begin
            seg_hi = CW'(1);
        end else if (r_pos >= r_count) begin
            seg_hi = cnt_m1;
        end else begin
            seg_hi = r_pos;
        end
    end
    assign seg_lo = seg_hi - CW'(1);

    // Restoring division: bring down the next dividend bit and try the subtraction.
    assign div_shift = {r_rem, r_quo[DW-1]};
    assign div_take  = !alu_is_neg;

    // The quotient is capped at 2^31; only a positive slope at the cap gets clipped.
    assign q_big      = (r_quo[DW-1:DWD] != '0) || (r_quo[DWD-1] && (r_quo[DWD-2:0] != '0));
    assign q_cap      = q_big ? {1'b1, {(DWD - 1){1'b0}}} : r_quo[DWD-1:0];
    assign slope_clip = !r_dy_neg && q_cap[DWD-1];
    always_comb begin
        priority if (slope_clip) begin
            slope_val = {1'b0, {(DWD - 1){1'b1}}};
        end else if (r_dy_neg) begin
            slope_val = -q_cap;
        end else begin
            slope_val = q_cap;
        end
    end
    assign mcand_val = slope_clip ? {1'b0, {(DWD - 1){1'b1}}} : q_cap;

    // Final sum: base ordinate plus the product scaled down by FRAC_BITS. The scaling
    // acts on the magnitude, so it truncates toward zero before the sign is applied.
    assign fin_m    = FW'(r_acc[PW-1:FRAC_BITS]);
    assign fin_ylo  = {{(FW - DWD){r_ylo[DWD-1]}}, r_ylo};
    assign fin_term = (r_slope_neg != r_dq_neg) ? -fin_m : fin_m;
    assign fin_sum  = fin_ylo + fin_term;
    assign fin_hi   = ($signed(fin_sum) > $signed(FIN_MAX));
    assign fin_lo   = ($signed(fin_sum) < $signed(FIN_MIN));

    // ------------------------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pli_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = pli_pkg::S_SEARCH;
                end
            end
            pli_pkg::S_SEARCH: begin
                if (search_stop) begin
                    priority if (!r_cmd && (r_dup || is_full)) begin
                        n_state = pli_pkg::S_IDLE;
                    end else if (!r_cmd) begin
                        n_state = pli_pkg::S_SHIFT_PRIME;
                    end else if (too_few) begin
                        n_state = pli_pkg::S_IDLE;
                    end else begin
                        n_state = pli_pkg::S_RD_LO;
                    end
                end
            end
            pli_pkg::S_SHIFT_PRIME: n_state = pli_pkg::S_SHIFT;
            pli_pkg::S_SHIFT: begin
                if (r_k == r_pos) begin
                    n_state = pli_pkg::S_IDLE;
                end
            end
            pli_pkg::S_RD_LO:   n_state = pli_pkg::S_RD_HI;
            pli_pkg::S_RD_HI:   n_state = pli_pkg::S_DIFF_DY;
            pli_pkg::S_DIFF_DY: n_state = pli_pkg::S_DIFF_DX;
            pli_pkg::S_DIFF_DX: n_state = pli_pkg::S_DIFF_DQ;
            pli_pkg::S_DIFF_DQ: n_state = pli_pkg::S_DIV;
            pli_pkg::S_DIV: begin
                if (r_step == '0) begin
                    n_state = pli_pkg::S_SLOPE;
                end
            end
            pli_pkg::S_SLOPE: n_state = pli_pkg::S_MUL;
            pli_pkg::S_MUL: begin
                if (r_step == '0) begin
                    n_state = pli_pkg::S_FINAL;
                end
            end
            pli_pkg::S_FINAL: n_state = pli_pkg::S_IDLE;
            default:          n_state = pli_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------------------
    // Sequencer outputs: memory addresses, write enable and the operands of the shared
    // unit. The search reads one entry ahead so that it compares one entry per cycle; the
    // insertion shift writes the registered read of entry k-1 into entry k while it reads entry k-2.
    // ------------------------------------------------------------------------------------
    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_k[IW-1:0];
        wr_x    = r_rd_x;
        wr_y    = r_rd_y;
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        finish  = 1'b0;
        unique case (r_state)
            pli_pkg::S_IDLE: begin
                rd_addr = '0;
            end
            pli_pkg::S_SEARCH: begin
                rd_addr = pos_p1[IW-1:0];
                alu_a   = {{(AW - DWD){r_x[DWD-1]}}, r_x};
                alu_b   = {{(AW - DWD){r_rd_x[DWD-1]}}, r_rd_x};
                finish  = search_stop && ((!r_cmd && (r_dup || is_full)) || (r_cmd && too_few));
            end
            pli_pkg::S_SHIFT_PRIME: begin
                rd_addr = cnt_m1[IW-1:0];
            end
            pli_pkg::S_SHIFT: begin
                rd_addr = k_m2[IW-1:0];
                wr_en   = 1'b1;
                if (r_k == r_pos) begin
                    wr_addr = r_pos[IW-1:0];
                    wr_x    = r_x;
                    wr_y    = r_y;
                    finish  = 1'b1;
                end
            end
            pli_pkg::S_RD_LO: begin
                rd_addr = seg_lo[IW-1:0];
            end
            pli_pkg::S_RD_HI: begin
                rd_addr = seg_hi[IW-1:0];
            end
            pli_pkg::S_DIFF_DY: begin
                alu_a = {{(AW - DWD){r_rd_y[DWD-1]}}, r_rd_y};
                alu_b = {{(AW - DWD){r_ylo[DWD-1]}}, r_ylo};
            end
            pli_pkg::S_DIFF_DX: begin
                alu_a = {{(AW - DWD){r_xhi[DWD-1]}}, r_xhi};
                alu_b = {{(AW - DWD){r_xlo[DWD-1]}}, r_xlo};
            end
            pli_pkg::S_DIFF_DQ: begin
                alu_a = {{(AW - DWD){r_x[DWD-1]}}, r_x};
                alu_b = {{(AW - DWD){r_xlo[DWD-1]}}, r_xlo};
            end
            pli_pkg::S_DIV: begin
                alu_a = {1'b0, div_shift};
                alu_b = {2'b00, r_dx};
            end
            pli_pkg::S_SLOPE: begin
                alu_sub = 1'b0;
            end
            pli_pkg::S_MUL: begin
                alu_sub = 1'b0;
                alu_a   = {1'b0, r_acc[PW-1:33]};
                alu_b   = r_acc[0] ? {2'b00, r_mcand} : '0;
            end
            pli_pkg::S_FINAL: begin
                finish = 1'b1;
            end
            default: begin
                finish = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------------------
    // Table memories.
    // ------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_x[wr_addr] <= wr_x;
            r_mem_y[wr_addr] <= wr_y;
        end
        r_rd_x <= r_mem_x[rd_addr];
        r_rd_y <= r_mem_y[rd_addr];
    end

    // ------------------------------------------------------------------------------------
    // Control registers. The count grows on the last cycle of an insertion, on the same
    // edge that raises the result strobe.
    // ------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= finish;
            if ((r_state == pli_pkg::S_SHIFT) && (r_k == r_pos)) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Working and result registers.
    // ------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pli_pkg::S_IDLE: begin
                if (accept) begin
                    r_cmd <= i_cmd;
                    r_x   <= i_x_value;
                    r_y   <= i_y_value;
                    r_pos <= '0;
                    r_dup <= 1'b0;
                end
            end
            pli_pkg::S_SEARCH: begin
                if (!search_stop) begin
                    r_pos <= pos_p1;
                    r_dup <= (alu_res == '0);
                end else begin
                    r_k <= r_count;
                end
                r_out_value <= '0;
                r_out_slope <= '0;
                r_out_sat   <= 1'b0;
                priority if (!r_cmd && r_dup) begin
                    r_out_status <= pli_pkg::ST_DUP;
                end else if (!r_cmd && is_full) begin
                    r_out_status <= pli_pkg::ST_FULL;
                end else begin
                    r_out_status <= pli_pkg::ST_FEW;
                end
            end
            pli_pkg::S_SHIFT_PRIME: begin
                r_k <= r_k;
            end
            pli_pkg::S_SHIFT: begin
                r_k          <= r_k - CW'(1);
                r_out_value  <= '0;
                r_out_slope  <= '0;
                r_out_sat    <= 1'b0;
                r_out_status <= pli_pkg::ST_OK;
            end
            pli_pkg::S_RD_LO: begin
                r_sat <= 1'b0;
            end
            pli_pkg::S_RD_HI: begin
                r_xlo <= r_rd_x;
                r_ylo <= r_rd_y;
            end
            pli_pkg::S_DIFF_DY: begin
                r_xhi    <= r_rd_x;
                r_dy_neg <= alu_is_neg;
                r_quo    <= {alu_mag, {FRAC_BITS{1'b0}}};
            end
            pli_pkg::S_DIFF_DX: begin
                // Breakpoints ascend strictly, so dx is positive and fits 32 bits.
                r_dx <= alu_res[DWD-1:0];
            end
            pli_pkg::S_DIFF_DQ: begin
                r_dq_neg <= alu_is_neg;
                r_dq_mag <= alu_mag;
                r_rem    <= '0;
                r_step   <= SCW'(DW - 1);
            end
            pli_pkg::S_DIV: begin
                r_rem  <= div_take ? alu_res[DWD-1:0] : div_shift[DWD-1:0];
                r_quo  <= {r_quo[DW-2:0], div_take};
                r_step <= r_step - SCW'(1);
            end
            pli_pkg::S_SLOPE: begin
                r_slope     <= slope_val;
                r_slope_neg <= r_dy_neg && (q_cap != '0);
                r_sat       <= slope_clip;
                r_mcand     <= mcand_val;
                r_acc       <= {33'd0, r_dq_mag};
                r_step      <= SCW'(pli_pkg::MUL_STEPS - 1);
            end
            pli_pkg::S_MUL: begin
                r_acc  <= {1'b0, alu_res[32:0], r_acc[32:1]};
                r_step <= r_step - SCW'(1);
            end
            pli_pkg::S_FINAL: begin
                priority if (fin_hi) begin
                    r_out_value <= FIN_MAX[DWD-1:0];
                end else if (fin_lo) begin
                    r_out_value <= FIN_MIN[DWD-1:0];
                end else begin
                    r_out_value <= fin_sum[DWD-1:0];
                end
                r_out_slope  <= r_slope;
                r_out_sat    <= r_sat || fin_hi || fin_lo;
                r_out_status <= pli_pkg::ST_OK;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // ------------------------------------------------------------------------------------
    // Result ports. The point count is read straight from the count register, which has
    // already taken its new value when the strobe is high.
    // ------------------------------------------------------------------------------------
    assign cnt_wide      = (CW + 5)'(r_count);
    assign o_valid       = r_valid;
    assign o_value       = $signed(r_out_value);
    assign o_slope       = $signed(r_out_slope);
    assign o_status      = r_out_status;
    assign o_saturated   = r_out_sat;
    assign o_point_count = cnt_wide[pli_pkg::CNT_OUT_W-1:0];

    // ------------------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------------------
    `PLI_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy, "result strobe while busy")
    `PLI_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, accept, busy || o_valid, "accepted item lost")
    `PLI_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX, "count beyond table")
    `PLI_ASSERT_SAME(a_count_strobe, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_count), o_valid && (r_out_status == pli_pkg::ST_OK), "count moved without a result")
    `PLI_ASSERT_SAME(a_shift_order, i_clk, i_rst_n, r_state == pli_pkg::S_SHIFT, r_k >= r_pos, "shift passed insert slot")

endmodule
